@@ sv/stfl_pkg.sv @@
// ----------------------------------------------------------------------------
// stfl_pkg
// shared types and codes for the slot table with first/last allocation
// ----------------------------------------------------------------------------
package stfl_pkg;

    // action codes
    localparam logic [3:0] ACT_SET_AT   = 4'd0;
    localparam logic [3:0] ACT_SET_LOW  = 4'd1;
    localparam logic [3:0] ACT_SET_HIGH = 4'd2;
    localparam logic [3:0] ACT_GET_AT   = 4'd3;
    localparam logic [3:0] ACT_GET_LOW  = 4'd4;
    localparam logic [3:0] ACT_GET_HIGH = 4'd5;
    localparam logic [3:0] ACT_RM_AT    = 4'd6;
    localparam logic [3:0] ACT_RM_LOW   = 4'd7;
    localparam logic [3:0] ACT_RM_HIGH  = 4'd8;
    localparam logic [3:0] ACT_UPD_AT   = 4'd9;
    localparam logic [3:0] ACT_UPD_LOW  = 4'd10;
    localparam logic [3:0] ACT_UPD_HIGH = 4'd11;
    localparam logic [3:0] ACT_SWAP     = 4'd12;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NONE  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_TAKEN = 2'd3;

    // action groups
    localparam logic [2:0] GRP_SET   = 3'd0;
    localparam logic [2:0] GRP_GET   = 3'd1;
    localparam logic [2:0] GRP_RM    = 3'd2;
    localparam logic [2:0] GRP_UPD   = 3'd3;
    localparam logic [2:0] GRP_SWAP  = 3'd4;
    localparam logic [2:0] GRP_OTHER = 3'd5;

    // slot choice
    localparam logic [1:0] MODE_AT   = 2'd0;
    localparam logic [1:0] MODE_LOW  = 2'd1;
    localparam logic [1:0] MODE_HIGH = 2'd2;

    // slots_in_use after reset
    localparam logic [6:0] CFG_RESET = 7'd64;

    typedef struct packed {
        logic [3:0]  action;
        logic [7:0]  slot_index;
        logic [7:0]  second_index;
        logic [31:0] element;
        logic        element_present;
    } t_in_word;

    typedef struct packed {
        logic [1:0]  status;
        logic [5:0]  found_index;
        logic [31:0] data_out;
        logic        data_valid;
        logic [6:0]  occupied;
        logic        is_full;
        logic        is_empty;
    } t_out_word;

endpackage

@@ sv/stfl_cell.sv @@
// ----------------------------------------------------------------------------
// stfl_cell
// one slot of the table: occupancy bit and data word
// ----------------------------------------------------------------------------
module stfl_cell #(
    parameter int DATA_WIDTH = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic                  i_wr_valid,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    output logic                  o_valid,
    output logic [DATA_WIDTH-1:0] o_data
);
    logic                  r_valid;
    logic [DATA_WIDTH-1:0] r_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_wr_en) begin
            r_valid <= i_wr_valid;
        end
    end

    // data needs no reset, an empty slot is never read out
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_data <= i_wr_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

@@ sv/stfl_scan.sv @@
// ----------------------------------------------------------------------------
// stfl_scan
// lowest and highest candidate slot as one-hot vectors, log-depth prefix or
// ----------------------------------------------------------------------------
module stfl_scan #(
    parameter int SLOTS = 64
) (
    input  logic [SLOTS-1:0] i_cand,
    output logic [SLOTS-1:0] o_first,
    output logic [SLOTS-1:0] o_last,
    output logic             o_any
);
    localparam int LV = $clog2(SLOTS);

    logic [SLOTS-1:0] lo [0:LV];
    logic [SLOTS-1:0] hi [0:LV];

    always_comb begin
        lo[0] = i_cand;
        hi[0] = i_cand;
        for (int l = 0; l < LV; l++) begin
            lo[l+1] = lo[l] | (lo[l] << (1 << l));
            hi[l+1] = hi[l] | (hi[l] >> (1 << l));
        end
        // a candidate wins when nothing below (or above) it is a candidate
        o_first = i_cand & ~(lo[LV] << 1);
        o_last  = i_cand & ~(hi[LV] >> 1);
        o_any   = |i_cand;
    end

endmodule

@@ sv/slot_table_first_last_alloc_core.sv @@
// ----------------------------------------------------------------------------
// slot_table_first_last_alloc_core
// slot table with indexed, lowest-free / highest-free set and
// lowest / highest occupied get, remove, update, plus swap of two slots
// ----------------------------------------------------------------------------
// each input word goes through a scan cycle, then an execute cycle, and the
// next word is taken only as the current one finishes (an output stall holds it)
// the scan cycle registers the one-hot slot choice from the priority network,
// the execute cycle reads the chosen cells, writes them and fills the output
// reset (sync, active low): every slot empty, count zero, slots_in_use = 64,
// no clearing pass, the block takes words in the first cycle after reset
// ----------------------------------------------------------------------------
module slot_table_first_last_alloc_core #(
    parameter int SLOTS      = 64,
    parameter int DATA_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration: slots_in_use
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [6:0]        i_cfg_data,
    // input words
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  stfl_pkg::t_in_word  i_in_word,
    // result words
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output stfl_pkg::t_out_word o_out_word
);
    import stfl_pkg::*;

    // count / length width, at least the 7 bits of the register
    localparam int LW = ($clog2(SLOTS + 1) > 7) ? $clog2(SLOTS + 1) : 7;
    // compare width for 8-bit indices against the length
    localparam int CW = (LW > 8) ? LW : 8;
    // slot number width
    localparam int IW = $clog2(SLOTS);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_EXEC = 2'd2;

    // control and configuration
    logic [1:0]      r_state;
    logic [1:0]      n_state;
    logic [6:0]      r_cfg;
    logic [LW-1:0]   r_count;
    logic [LW-1:0]   n_count;
    t_in_word        r_item;
    logic            r_out_valid;
    t_out_word       r_out;
    t_out_word       n_out;

    // registered slot choice from the scan cycle
    logic [SLOTS-1:0] r_sel_a;
    logic [SLOTS-1:0] r_sel_b;
    logic             r_hit;
    logic [SLOTS-1:0] n_sel_a;
    logic [SLOTS-1:0] n_sel_b;
    logic             n_hit;

    // cell row
    logic [SLOTS-1:0]      cell_valid;
    logic [DATA_WIDTH-1:0] cell_data [SLOTS];
    logic [SLOTS-1:0]      cell_wr_en;
    logic [SLOTS-1:0]      cell_wr_valid;
    logic [DATA_WIDTH-1:0] cell_wr_data [SLOTS];

    // decode
    logic [2:0]      grp;
    logic [1:0]      mode;
    logic [LW-1:0]   len;
    logic [CW-1:0]   len_c;
    logic [CW-1:0]   idx_c;
    logic [CW-1:0]   idx2_c;
    logic            idx_in;
    logic            idx2_in;
    logic [SLOTS-1:0] idx_oh;
    logic [SLOTS-1:0] idx2_oh;
    logic [SLOTS-1:0] cand;
    logic [SLOTS-1:0] first_oh;
    logic [SLOTS-1:0] last_oh;
    logic             any_hit;

    // execute
    logic                  fire;
    logic                  a_valid;
    logic                  b_valid;
    logic [DATA_WIDTH-1:0] a_data;
    logic [DATA_WIDTH-1:0] b_data;
    logic [IW-1:0]         a_pos;
    logic [IW+5:0]         pos_ext;
    logic                  wr_a;
    logic                  wr_b;
    logic                  wa_valid;
    logic [DATA_WIDTH-1:0] wa_data;
    logic [DATA_WIDTH+31:0] elem_ext;
    logic [DATA_WIDTH+31:0] dout_ext;
    logic [DATA_WIDTH-1:0] elem_w;

    // ------------------------------------------------------------------------
    // configuration, the user must write only while the block is idle; the block does not enforce it
    // ------------------------------------------------------------------------
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            r_cfg <= i_cfg_data;
        end
    end

    // register above the table size acts as the table size
    always_comb begin
        if (LW'(r_cfg) > LW'(SLOTS)) begin
            len = LW'(SLOTS);
        end else begin
            len = LW'(r_cfg);
        end
    end

    // ------------------------------------------------------------------------
    // action decode
    // ------------------------------------------------------------------------
    always_comb begin
        unique case (r_item.action) inside
            ACT_SET_AT, ACT_SET_LOW, ACT_SET_HIGH:    grp = GRP_SET;
            ACT_GET_AT, ACT_GET_LOW, ACT_GET_HIGH:    grp = GRP_GET;
            ACT_RM_AT, ACT_RM_LOW, ACT_RM_HIGH:       grp = GRP_RM;
            ACT_UPD_AT, ACT_UPD_LOW, ACT_UPD_HIGH:    grp = GRP_UPD;
            ACT_SWAP:                                 grp = GRP_SWAP;
            default:                                  grp = GRP_OTHER;
        endcase
        unique case (r_item.action) inside
            ACT_SET_LOW, ACT_GET_LOW, ACT_RM_LOW, ACT_UPD_LOW:     mode = MODE_LOW;
            ACT_SET_HIGH, ACT_GET_HIGH, ACT_RM_HIGH, ACT_UPD_HIGH: mode = MODE_HIGH;
            default:                                               mode = MODE_AT;
        endcase
    end

    // ------------------------------------------------------------------------
    // scan cycle: candidates, index decode, priority choice
    // ------------------------------------------------------------------------
    assign len_c   = CW'(len);
    assign idx_c   = CW'(r_item.slot_index);
    assign idx2_c  = CW'(r_item.second_index);
    assign idx_in  = idx_c < len_c;
    assign idx2_in = idx2_c < len_c;

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            idx_oh[i]  = (CW'(i) == idx_c);
            idx2_oh[i] = (CW'(i) == idx2_c);
            // set looks for an empty slot, the rest for an occupied one
            cand[i]    = (LW'(i) < len) && (cell_valid[i] == (grp != GRP_SET));
        end
    end

    stfl_scan #(
        .SLOTS (SLOTS)
    ) u_scan (
        .i_cand  (cand),
        .o_first (first_oh),
        .o_last  (last_oh),
        .o_any   (any_hit)
    );

    always_comb begin
        n_sel_b = idx2_oh;
        unique case (mode)
            MODE_LOW: begin
                n_sel_a = first_oh;
                n_hit   = any_hit;
            end
            MODE_HIGH: begin
                n_sel_a = last_oh;
                n_hit   = any_hit;
            end
            default: begin
                n_sel_a = idx_oh;
                n_hit   = idx_in && ((grp != GRP_SWAP) || idx2_in);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_SCAN) begin
            r_sel_a <= n_sel_a;
            r_sel_b <= n_sel_b;
            r_hit   <= n_hit;
        end
    end

    // ------------------------------------------------------------------------
    // execute cycle: read chosen cells, decide, write back
    // ------------------------------------------------------------------------
    assign fire = (r_state == S_EXEC) && (!r_out_valid || i_out_ready);

    // gather the chosen slots over the row
    always_comb begin
        a_valid = 1'b0;
        b_valid = 1'b0;
        a_data  = '0;
        b_data  = '0;
        a_pos   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (r_sel_a[i]) begin
                a_valid = a_valid | cell_valid[i];
                a_data  = a_data | cell_data[i];
                a_pos   = a_pos | IW'(i);
            end
            if (r_sel_b[i]) begin
                b_valid = b_valid | cell_valid[i];
                b_data  = b_data | cell_data[i];
            end
        end
    end

    assign elem_ext = {DATA_WIDTH'(0), r_item.element};
    assign elem_w   = elem_ext[DATA_WIDTH-1:0];
    assign dout_ext = {32'(0), a_data};
    assign pos_ext  = {6'(0), a_pos};

    always_comb begin
        n_out             = '0;
        n_out.status      = ST_OK;
        n_out.found_index = r_item.slot_index[5:0];
        wr_a              = 1'b0;
        wr_b              = 1'b0;
        wa_valid          = 1'b0;
        wa_data           = '0;
        n_count           = r_count;

        if (grp == GRP_SWAP) begin
            if (!r_hit) begin
                n_out.status = ST_RANGE;
            end else begin
                // first slot takes the second's contents and the other way round
                wr_a     = 1'b1;
                wr_b     = 1'b1;
                wa_valid = b_valid;
                wa_data  = b_data;
            end
        end else if (grp != GRP_OTHER) begin
            if (!r_hit) begin
                if (mode == MODE_AT) begin
                    n_out.status = ST_RANGE;
                end else begin
                    n_out.status      = ST_NONE;
                    n_out.found_index = '0;
                end
            end else begin
                if (mode != MODE_AT) begin
                    n_out.found_index = pos_ext[5:0];
                end
                case (grp)
                    GRP_SET: begin
                        if (a_valid) begin
                            n_out.status = ST_TAKEN;
                        end else begin
                            wr_a     = 1'b1;
                            wa_valid = r_item.element_present;
                            wa_data  = elem_w;
                        end
                    end
                    GRP_GET, GRP_RM: begin
                        if (!a_valid) begin
                            n_out.status = ST_NONE;
                        end else begin
                            n_out.data_out   = dout_ext[31:0];
                            n_out.data_valid = 1'b1;
                            wr_a             = (grp == GRP_RM);
                        end
                    end
                    default: begin
                        wr_a     = 1'b1;
                        wa_valid = r_item.element_present;
                        wa_data  = elem_w;
                    end
                endcase
            end
        end

        // count follows the real occupancy change, swap leaves it alone
        if (wr_a && !wr_b) begin
            if (a_valid && !wa_valid) begin
                n_count = r_count - LW'(1);
            end else if (!a_valid && wa_valid) begin
                n_count = r_count + LW'(1);
            end
        end

        n_out.occupied = n_count[6:0];
        n_out.is_full  = (n_count >= len);
        n_out.is_empty = (n_count == '0);
    end

    // per-cell write strobes, a swap with itself writes the same contents
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            if (wr_a && r_sel_a[i]) begin
                cell_wr_en[i]    = fire;
                cell_wr_valid[i] = wa_valid;
                cell_wr_data[i]  = wa_data;
            end else begin
                cell_wr_en[i]    = fire && wr_b && r_sel_b[i];
                cell_wr_valid[i] = a_valid;
                cell_wr_data[i]  = a_data;
            end
        end
    end

    // ------------------------------------------------------------------------
    // cell row
    // ------------------------------------------------------------------------
    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        stfl_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_wr_en    (cell_wr_en[g]),
            .i_wr_valid (cell_wr_valid[g]),
            .i_wr_data  (cell_wr_data[g]),
            .o_valid    (cell_valid[g]),
            .o_data     (cell_data[g])
        );
    end

    // ------------------------------------------------------------------------
    // sequencing and handshakes
    // ------------------------------------------------------------------------
    // next word may enter in the cycle the current one finishes
    assign o_in_ready = (r_state == S_IDLE) || fire;

    always_comb begin
        unique case (r_state)
            S_IDLE:  n_state = (i_in_valid) ? S_SCAN : S_IDLE;
            S_SCAN:  n_state = S_EXEC;
            S_EXEC: begin
                if (fire) begin
                    n_state = (i_in_valid) ? S_SCAN : S_IDLE;
                end else begin
                    n_state = S_EXEC;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (fire) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_item <= i_in_word;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for slot_table_first_last_alloc_core: a short table of
// directed words, then random words under several slots_in_use settings and
// idle patterns; each result word is checked against its typed result or a bench-side model
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stfl_pkg::*;

    localparam int SLOTS       = 64;
    localparam int RUN_ITEMS   = 230;     // random words per slots_in_use setting
    localparam int PHASES      = 8;
    localparam int HOLD_CYCLES = 120;     // long receiver hold-off
    localparam int CYCLE_LIMIT = 200000;

    // action codes the block ignores
    localparam logic [3:0] ACT_UNUSED_LO = 4'd13;
    localparam logic [3:0] ACT_UNUSED_HI = 4'd15;

    // one row of the directed table
    typedef struct {
        t_in_word  word;
        bit        typed;
        t_out_word result;
    } t_row;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       o_cfg_ready;
    logic [6:0] i_cfg_data  = '0;
    logic       i_in_valid  = 1'b0;
    logic       o_in_ready;
    t_in_word   i_in_word   = '0;
    logic       o_out_valid;
    logic       i_out_ready = 1'b0;
    t_out_word  o_out_word;

    // bench-side copy of the slot table
    logic [31:0] tbl_data    [SLOTS];
    bit          tbl_used    [SLOTS];
    int          used_count;
    logic [6:0]  cfg_slots;

    // slots_in_use for each random phase, extremes and out-of-range values included
    logic [6:0] limit_plan [PHASES] = '{7'd127, 7'd40, 7'd1, 7'd0, 7'd17, 7'd64, 7'd5, 7'd64};

    t_out_word pending [$];     // expected result words, oldest first
    t_row      script  [$];
    t_out_word oldest;
    int        errors       = 0;
    int        results_seen = 0;
    int        cycles       = 0;
    int        send_pct     = 0;  // chance the sender idles before a word
    int        stall_pct    = 0;  // chance the receiver drops ready
    bit        hold_armed   = 1'b0;
    bit        hold_done    = 1'b0;
    int        hold_left    = 0;

    slot_table_first_last_alloc_core #(
        .SLOTS      (SLOTS),
        .DATA_WIDTH (32)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // table model
    // ------------------------------------------------------------------------

    // slots actually exposed, values above the table size clamp to it
    function automatic int slot_limit();
        return (cfg_slots > SLOTS) ? SLOTS : int'(cfg_slots);
    endfunction

    // write one cell, the count follows the real change in occupancy
    function automatic void store_slot(int pos, logic [31:0] value, bit present);
        if (tbl_used[pos] && !present) begin
            used_count--;
        end else if (!tbl_used[pos] && present) begin
            used_count++;
        end
        tbl_data[pos] = present ? value : 32'd0;
        tbl_used[pos] = present;
    endfunction

    // applies one input word to the model and returns the result word it gives
    function automatic t_out_word apply_slot_action(t_in_word w);
        t_out_word   res;
        int          len;
        int          pos;
        int          k;
        int          i;
        bit          hit;
        bit          want;
        logic [2:0]  grp;
        logic [1:0]  mode;
        logic [31:0] held_data;
        bit          held_used;
        len = slot_limit();
        res = '0;
        res.found_index = w.slot_index[5:0];
        pos = 0;
        if (w.action == ACT_SWAP) begin
            if (w.slot_index >= len || w.second_index >= len) begin
                res.status = ST_RANGE;
            end else begin
                // a slot swapped with itself falls out unchanged
                held_data = tbl_data[w.slot_index];
                held_used = tbl_used[w.slot_index];
                tbl_data[w.slot_index]  = tbl_data[w.second_index];
                tbl_used[w.slot_index]  = tbl_used[w.second_index];
                tbl_data[w.second_index] = held_data;
                tbl_used[w.second_index] = held_used;
            end
        end else if (w.action < ACT_SWAP) begin
            grp  = 3'(w.action / 3);
            mode = 2'(w.action % 3);
            hit  = 1'b1;
            if (mode == MODE_AT) begin
                if (w.slot_index >= len) begin
                    res.status = ST_RANGE;
                    hit = 1'b0;
                end else begin
                    pos = w.slot_index;
                end
            end else begin
                // set looks for an empty slot, everything else for an occupied one
                want = (grp != GRP_SET);
                hit  = 1'b0;
                for (k = 0; k < len; k++) begin
                    i = (mode == MODE_HIGH) ? len - 1 - k : k;
                    if (!hit && tbl_used[i] == want) begin
                        pos = i;
                        hit = 1'b1;
                    end
                end
                if (hit) begin
                    res.found_index = 6'(pos);
                end else begin
                    res.status      = ST_NONE;
                    res.found_index = '0;
                end
            end
            if (hit) begin
                case (grp)
                    GRP_SET: begin
                        if (tbl_used[pos]) begin
                            res.status = ST_TAKEN;
                        end else begin
                            store_slot(pos, w.element, w.element_present);
                        end
                    end
                    GRP_GET, GRP_RM: begin
                        if (!tbl_used[pos]) begin
                            res.status = ST_NONE;
                        end else begin
                            res.data_out   = tbl_data[pos];
                            res.data_valid = 1'b1;
                            if (grp == GRP_RM) begin
                                store_slot(pos, 32'd0, 1'b0);
                            end
                        end
                    end
                    default: begin
                        // update: clearing an empty slot leaves the count alone
                        store_slot(pos, w.element, w.element_present);
                    end
                endcase
            end
        end
        res.occupied = 7'(used_count);
        res.is_full  = (used_count >= len);
        res.is_empty = (used_count == 0);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    function automatic t_in_word stim(logic [3:0] act, logic [7:0] idx, logic [7:0] idx2,
                                      logic [31:0] elem, logic present);
        return {act, idx, idx2, elem, present};
    endfunction

    // row checked against the model
    function automatic void add_step(t_in_word w);
        script.push_back('{w, 1'b0, t_out_word'('0)});
    endfunction

    // row with its result typed in
    function automatic void add_known_step(t_in_word w, logic [1:0] st, logic [5:0] fi,
                                           logic [31:0] d, logic dv, logic [6:0] occ,
                                           logic fu, logic em);
        t_out_word r;
        r.status      = st;
        r.found_index = fi;
        r.data_out    = d;
        r.data_valid  = dv;
        r.occupied    = occ;
        r.is_full     = fu;
        r.is_empty    = em;
        script.push_back('{w, 1'b1, r});
    endfunction

    // random word, mostly in range, with a few unknown actions
    function automatic t_in_word random_word();
        t_in_word w;
        int       len;
        int       pick;
        len = slot_limit();
        if ($urandom_range(0, 99) < 4) begin
            w.action = 4'($urandom_range(ACT_UNUSED_LO, ACT_UNUSED_HI));
        end else begin
            w.action = 4'($urandom_range(0, ACT_SWAP));
        end
        if (len > 0 && $urandom_range(0, 99) < 85) begin
            w.slot_index   = 8'($urandom_range(0, len - 1));
            w.second_index = 8'($urandom_range(0, len - 1));
        end else begin
            w.slot_index   = 8'($urandom_range(0, 255));
            w.second_index = 8'($urandom_range(0, 255));
        end
        pick = $urandom_range(0, 9);
        w.element = (pick == 0) ? 32'd0 : (pick == 1) ? 32'hFFFF_FFFF : 32'($urandom);
        w.element_present = ($urandom_range(0, 99) < 85);
        return w;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_word(input t_in_word w, input bit typed, input t_out_word known);
        t_out_word model_res;
        while ($urandom_range(0, 99) < send_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        // model always runs so its state tracks the block, typed rows win
        model_res = apply_slot_action(w);
        pending.push_back(typed ? known : model_res);
        @(negedge i_clk);
    endtask

    // new slots_in_use once the block has drained, then the phase's idle pattern
    task automatic write_slot_limit(input logic [6:0] value, input int idle_mode,
                                    input bit with_hold);
        while (pending.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_slots = value;
        case (idle_mode)
            1:       begin send_pct = 61; stall_pct = 0;  end
            2:       begin send_pct = 0;  stall_pct = 61; end
            3:       begin send_pct = 26; stall_pct = 26; end
            default: begin send_pct = 0;  stall_pct = 0;  end
        endcase
        if (with_hold) begin
            hold_armed = 1'b1;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    task automatic log_mismatch(input string msg);
        $display("mismatch: %s", msg);
        errors++;
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            log_mismatch($sformatf("result word %0d field %s got %0h expected %0h",
                                   results_seen, name, got, want));
        end
    endtask

    // result words are taken at the rising edge and compared with the oldest
    // expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            results_seen++;
            if (pending.size() == 0) begin
                log_mismatch($sformatf("result word %0d arrived with nothing expected",
                                       results_seen));
            end else begin
                oldest = pending.pop_front();
                check_field("status",      o_out_word.status,      oldest.status);
                check_field("found_index", o_out_word.found_index, oldest.found_index);
                check_field("data_out",    o_out_word.data_out,    oldest.data_out);
                check_field("data_valid",  o_out_word.data_valid,  oldest.data_valid);
                check_field("occupied",    o_out_word.occupied,    oldest.occupied);
                check_field("is_full",     o_out_word.is_full,     oldest.is_full);
                check_field("is_empty",    o_out_word.is_empty,    oldest.is_empty);
            end
        end
    end

    // receiver side: random stalls, plus one long hold-off that lets the block
    // fill up and push back on its input
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (hold_armed && !hold_done) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("slot_table_first_last_alloc_core test failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial begin
        int ph;
        cfg_slots  = CFG_RESET;
        used_count = 0;

        // empty table right after reset
        add_known_step(stim(ACT_GET_LOW, 8'h00, 8'h00, 32'h0, 1'b0),
                       ST_NONE, 6'd0, 32'h0, 1'b0, 7'd0, 1'b0, 1'b1);
        add_known_step(stim(ACT_RM_HIGH, 8'h00, 8'h00, 32'h0, 1'b0),
                       ST_NONE, 6'd0, 32'h0, 1'b0, 7'd0, 1'b0, 1'b1);
        // out of range index echoes its low bits
        add_known_step(stim(ACT_SET_AT, 8'd200, 8'h00, 32'h0, 1'b1),
                       ST_RANGE, 6'd8, 32'h0, 1'b0, 7'd0, 1'b0, 1'b1);
        add_known_step(stim(ACT_SET_AT, 8'h00, 8'h00, 32'hFFFF_FFFF, 1'b1),
                       ST_OK, 6'd0, 32'h0, 1'b0, 7'd1, 1'b0, 1'b0);
        // slot already taken
        add_known_step(stim(ACT_SET_AT, 8'h00, 8'h00, 32'h0, 1'b1),
                       ST_TAKEN, 6'd0, 32'h0, 1'b0, 7'd1, 1'b0, 1'b0);
        add_known_step(stim(ACT_SET_HIGH, 8'hFF, 8'hFF, 32'h0, 1'b1),
                       ST_OK, 6'd63, 32'h0, 1'b0, 7'd2, 1'b0, 1'b0);
        // set with no element keeps the slot empty and the count unchanged
        add_known_step(stim(ACT_SET_LOW, 8'h00, 8'h00, 32'hDEAD_BEEF, 1'b0),
                       ST_OK, 6'd1, 32'h0, 1'b0, 7'd2, 1'b0, 1'b0);
        add_known_step(stim(ACT_GET_AT, 8'h00, 8'h00, 32'h0, 1'b0),
                       ST_OK, 6'd0, 32'hFFFF_FFFF, 1'b1, 7'd2, 1'b0, 1'b0);
        add_known_step(stim(ACT_GET_HIGH, 8'h00, 8'h00, 32'h0, 1'b0),
                       ST_OK, 6'd63, 32'h0, 1'b1, 7'd2, 1'b0, 1'b0);
        add_known_step(stim(ACT_SET_AT, 8'hFF, 8'hFF, 32'h0, 1'b1),
                       ST_RANGE, 6'd63, 32'h0, 1'b0, 7'd2, 1'b0, 1'b0);
        add_step(stim(ACT_UPD_AT, 8'd63, 8'h00, 32'hA5A5_A5A5, 1'b1));
        // clearing an empty slot must not decrement
        add_known_step(stim(ACT_UPD_AT, 8'd5, 8'h00, 32'h0, 1'b0),
                       ST_OK, 6'd5, 32'h0, 1'b0, 7'd2, 1'b0, 1'b0);
        add_step(stim(ACT_SWAP, 8'd0, 8'd63, 32'h0, 1'b0));
        // swap with itself
        add_step(stim(ACT_SWAP, 8'd63, 8'd63, 32'h0, 1'b0));
        // swap with either index out of range
        add_known_step(stim(ACT_SWAP, 8'd0, 8'hFF, 32'h0, 1'b0),
                       ST_RANGE, 6'd0, 32'h0, 1'b0, 7'd2, 1'b0, 1'b0);
        add_known_step(stim(ACT_SWAP, 8'd64, 8'd63, 32'h0, 1'b0),
                       ST_RANGE, 6'd0, 32'h0, 1'b0, 7'd2, 1'b0, 1'b0);
        add_step(stim(ACT_GET_AT, 8'd0, 8'h00, 32'h0, 1'b0));
        add_step(stim(ACT_UPD_LOW, 8'h00, 8'h00, 32'h1234_5678, 1'b1));
        add_step(stim(ACT_UPD_HIGH, 8'h00, 8'h00, 32'h0, 1'b0));
        add_step(stim(ACT_RM_LOW, 8'h00, 8'h00, 32'h0, 1'b0));
        add_known_step(stim(ACT_UPD_HIGH, 8'h00, 8'h00, 32'h0, 1'b1),
                       ST_NONE, 6'd0, 32'h0, 1'b0, 7'd0, 1'b0, 1'b1);
        // unknown actions are ignored but still answer
        add_known_step(stim(ACT_UNUSED_LO, 8'h7F, 8'h00, 32'h0, 1'b1),
                       ST_OK, 6'd63, 32'h0, 1'b0, 7'd0, 1'b0, 1'b1);
        add_known_step(stim(ACT_UNUSED_HI, 8'h80, 8'h00, 32'hFFFF_FFFF, 1'b1),
                       ST_OK, 6'd0, 32'h0, 1'b0, 7'd0, 1'b0, 1'b1);
        add_known_step(stim(ACT_RM_AT, 8'd63, 8'h00, 32'h0, 1'b0),
                       ST_NONE, 6'd63, 32'h0, 1'b0, 7'd0, 1'b0, 1'b1);
        add_step(stim(ACT_SET_LOW, 8'h00, 8'h00, 32'h0000_0001, 1'b1));

        // hold synchronous reset, then release it at a falling edge
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (script[n]) begin
            send_word(script[n].word, script[n].typed, script[n].result);
        end

        // random phases, each under its own slots_in_use and idle pattern;
        // every setting change waits for the block to drain
        for (ph = 0; ph < PHASES; ph++) begin
            i_in_valid <= 1'b0;
            write_slot_limit(limit_plan[ph], ph % 4, ph == 4);
            repeat (RUN_ITEMS) send_word(random_word(), 1'b0, t_out_word'('0));
        end
        i_in_valid <= 1'b0;

        while (pending.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        if (errors == 0) begin
            $display("slot_table_first_last_alloc_core test passed");
        end else begin
            $display("slot_table_first_last_alloc_core test failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/stfl_pkg.sv
sv/stfl_cell.sv
sv/stfl_scan.sv
sv/slot_table_first_last_alloc_core.sv
tb/sv/testbench.sv
